// ===== hw/rtl/lfu_pkg.sv =====
// Shared types and constants for the LFU page replacement block.
// No dependencies; imported by lfu_cell and lfu_page_replacement.
package lfu_pkg;

  localparam int CNT_W    = 32;
  localparam int LIMIT_W  = 10;
  localparam int OUT_KEY_W = 40;
  localparam int GRP_SIZE = 16;

  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
  localparam logic [CNT_W-1:0]   CNT_ONE     = CNT_W'(1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  // sequencer phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_LOOK   = 2'd1;
  localparam logic [1:0] PH_REDUCE = 2'd2;
  localparam logic [1:0] PH_UPDATE = 2'd3;

  // update command broadcast to every cell
  typedef struct packed {
    logic hit_move;
    logic shift_in;
    logic replace_front;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/lfu_cell.sv =====
// One list position of the LFU chain: holds a key and its use count.
// Depends on lfu_pkg; instantiated in a row by lfu_page_replacement.
module lfu_cell import lfu_pkg::*; #(
  parameter int IDX      = 0,
  parameter int KEY_BITS = 40,
  parameter int IDX_W    = 9,
  parameter int OCC_W    = 10
) (
  input  logic                clk,
  input  cell_ctl_t           ctl,
  input  logic [OCC_W-1:0]    occ,
  input  logic [IDX_W-1:0]    hit_pos,
  input  logic [CNT_W-1:0]    hit_cnt,
  input  logic [KEY_BITS-1:0] look_key,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic [CNT_W-1:0]    left_cnt,
  input  logic [KEY_BITS-1:0] right_key,
  input  logic [CNT_W-1:0]    right_cnt,
  input  logic                right_lt,
  output logic [KEY_BITS-1:0] key_o,
  output logic [CNT_W-1:0]    cnt_o,
  output logic                lt_o,
  output logic                match_o
);

  localparam logic [OCC_W-1:0] MY_OCC   = OCC_W'(IDX);
  localparam logic [IDX_W-1:0] MY_POS   = IDX_W'(IDX);
  localparam bit               IS_FRONT = (IDX == 0);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                active;
  logic                at_or_after;

  assign active      = (MY_OCC < occ);
  assign at_or_after = (MY_POS >= hit_pos);
  assign match_o     = active && (key_r == look_key);
  // entry behind the hit position whose count the bumped entry passes
  assign lt_o        = active && (MY_POS > hit_pos) && (cnt_r < hit_cnt);
  assign key_o       = key_r;
  assign cnt_o       = cnt_r;

  always_comb begin
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    if (ctl.hit_move) begin
      if (at_or_after && right_lt) begin
        // pull the passed entry one place toward the front
        key_nxt = right_key;
        cnt_nxt = right_cnt;
      end else if ((MY_POS == hit_pos) || (at_or_after && lt_o)) begin
        key_nxt = look_key;
        cnt_nxt = hit_cnt;
      end
    end else if (ctl.shift_in || (ctl.replace_front && IS_FRONT)) begin
      key_nxt = left_key;
      cnt_nxt = left_cnt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// ===== hw/rtl/lfu_page_replacement.sv =====
// LFU page replacement: a row of lfu_cell list positions with lookup and update control.
// Depends on lfu_pkg and lfu_cell.
//
// Each request passes LOOK, which compares the key in every cell and reduces matches
// per group of 16 cells, REDUCE, which merges the groups into hit position and count,
// and UPDATE, in which the whole chain shifts or reorders. busy is high in LOOK and
// REDUCE; a new request may start in the update cycle. The result appears on the out_
// ports for exactly one cycle with out_valid high, the cycle after the update; the
// receiver cannot stall it, so it must take every strobe. frame_limit is written
// through cfg_valid / cfg_data (cfg_ready is always high); the user must write it only
// while no request is in flight; the block itself does not enforce this. Values of 0
// act as 1 and values above MAX_FRAMES act as MAX_FRAMES.
module lfu_page_replacement import lfu_pkg::*; #(
  parameter int MAX_FRAMES = 512,
  parameter int KEY_BITS   = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OUT_KEY_W-1:0] in_page_key,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output logic                 out_valid,
  output logic                 out_was_hit,
  output logic                 out_evicted_valid,
  output logic [OUT_KEY_W-1:0] out_evicted_key,
  output logic [CNT_W-1:0]     out_hit_total,
  output logic [CNT_W-1:0]     out_miss_total
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int OCC_W = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
  localparam int NGRP  = (MAX_FRAMES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NPAD  = NGRP * GRP_SIZE;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAMES);
  localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(MAX_FRAMES);

  logic [1:0]           phase_r, phase_nxt;
  logic                 accept;
  logic [KEY_BITS-1:0]  key_r;
  logic [63:0]          in_wide;
  logic [LIMIT_W-1:0]   limit_r;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic [CNT_W-1:0]     hits_r, misses_r, hits_nxt, misses_nxt;

  // per-cell chain signals
  logic [KEY_BITS-1:0]  key_a   [MAX_FRAMES];
  logic [CNT_W-1:0]     cnt_a   [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] lt_a;
  logic [MAX_FRAMES-1:0] match_a;
  cell_ctl_t            ctl;

  // group reduction
  logic [NPAD-1:0]      match_p;
  logic [IDX_W-1:0]     pos_m   [NPAD];
  logic [CNT_W-1:0]     cnt_m   [NPAD];
  logic [NGRP-1:0]      g_hit_r, g_hit_nxt;
  logic [IDX_W-1:0]     g_pos_r [NGRP];
  logic [IDX_W-1:0]     g_pos_nxt [NGRP];
  logic [CNT_W-1:0]     g_cnt_r [NGRP];
  logic [CNT_W-1:0]     g_cnt_nxt [NGRP];

  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]     hcnt_r, hcnt_nxt;
  logic [CNT_W-1:0]     old_cnt;

  logic [CMP_W-1:0]     lim_use;
  logic                 full;
  logic                 in_update;
  logic [63:0]          ev_wide;

  assign busy      = (phase_r == PH_LOOK) || (phase_r == PH_REDUCE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign in_wide   = 64'(in_page_key);
  assign in_update = (phase_r == PH_UPDATE);

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE:   phase_nxt = accept ? PH_LOOK : PH_IDLE;
      PH_LOOK:   phase_nxt = PH_REDUCE;
      PH_REDUCE: phase_nxt = PH_UPDATE;
      PH_UPDATE: phase_nxt = accept ? PH_LOOK : PH_IDLE;
      default:   phase_nxt = PH_IDLE;
    endcase
  end

  // ---- cell row ----
  genvar j;
  generate
    for (j = 0; j < MAX_FRAMES; j++) begin : g_cell
      logic [KEY_BITS-1:0] lkey, rkey;
      logic [CNT_W-1:0]    lcnt, rcnt;
      logic                rlt;
      if (j == 0) begin : g_front
        assign lkey = key_r;
        assign lcnt = CNT_ONE;
      end else begin : g_mid
        assign lkey = key_a[j-1];
        assign lcnt = cnt_a[j-1];
      end
      if (j == MAX_FRAMES - 1) begin : g_back
        assign rkey = '0;
        assign rcnt = '0;
        assign rlt  = 1'b0;
      end else begin : g_inner
        assign rkey = key_a[j+1];
        assign rcnt = cnt_a[j+1];
        assign rlt  = lt_a[j+1];
      end
      lfu_cell #(
        .IDX(j), .KEY_BITS(KEY_BITS), .IDX_W(IDX_W), .OCC_W(OCC_W)
      ) u_cell (
        .clk(clk), .ctl(ctl), .occ(occ_r), .hit_pos(pos_r), .hit_cnt(hcnt_r),
        .look_key(key_r), .left_key(lkey), .left_cnt(lcnt),
        .right_key(rkey), .right_cnt(rcnt), .right_lt(rlt),
        .key_o(key_a[j]), .cnt_o(cnt_a[j]), .lt_o(lt_a[j]), .match_o(match_a[j])
      );
    end

    for (j = 0; j < NPAD; j++) begin : g_pad
      if (j < MAX_FRAMES) begin : g_real
        assign match_p[j] = match_a[j];
        assign pos_m[j]   = match_a[j] ? IDX_W'(j) : '0;
        assign cnt_m[j]   = match_a[j] ? cnt_a[j] : '0;
      end else begin : g_none
        assign match_p[j] = 1'b0;
        assign pos_m[j]   = '0;
        assign cnt_m[j]   = '0;
      end
    end
  endgenerate

  // ---- lookup: OR-reduce each group of cells (keys are unique) ----
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      g_hit_nxt[g] = 1'b0;
      g_pos_nxt[g] = '0;
      g_cnt_nxt[g] = '0;
      for (int l = 0; l < GRP_SIZE; l++) begin
        g_hit_nxt[g] = g_hit_nxt[g] | match_p[g*GRP_SIZE + l];
        g_pos_nxt[g] = g_pos_nxt[g] | pos_m[g*GRP_SIZE + l];
        g_cnt_nxt[g] = g_cnt_nxt[g] | cnt_m[g*GRP_SIZE + l];
      end
    end
  end

  // ---- merge groups, bump count ----
  always_comb begin
    hit_nxt = |g_hit_r;
    pos_nxt = '0;
    old_cnt = '0;
    for (int g = 0; g < NGRP; g++) begin
      pos_nxt = pos_nxt | g_pos_r[g];
      old_cnt = old_cnt | g_cnt_r[g];
    end
    hcnt_nxt = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + CNT_ONE;
  end

  // ---- update ----
  always_comb begin
    lim_use = CMP_W'(limit_r);
    if (lim_use == '0) lim_use = CMP_W'(1);
    if (lim_use > MAX_CMP) lim_use = MAX_CMP;
  end

  assign full = (CMP_W'(occ_r) >= lim_use);

  always_comb begin
    ctl.hit_move      = in_update && hit_r;
    ctl.shift_in      = in_update && !hit_r && !full;
    ctl.replace_front = in_update && !hit_r && full;
  end

  always_comb begin
    occ_nxt    = occ_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (in_update) begin
      if (hit_r) begin
        if (hits_r != CNT_MAX) hits_nxt = hits_r + CNT_ONE;
      end else begin
        if (misses_r != CNT_MAX) misses_nxt = misses_r + CNT_ONE;
        if (!full) occ_nxt = occ_r + OCC_W'(1);
      end
    end
  end

  assign ev_wide = 64'(key_a[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      limit_r   <= LIMIT_RESET;
      occ_r     <= '0;
      hits_r    <= '0;
      misses_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      occ_r     <= occ_nxt;
      hits_r    <= hits_nxt;
      misses_r  <= misses_nxt;
      out_valid <= in_update;
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) key_r <= in_wide[KEY_BITS-1:0];
    if (phase_r == PH_LOOK) begin
      g_hit_r <= g_hit_nxt;
      for (int g = 0; g < NGRP; g++) begin
        g_pos_r[g] <= g_pos_nxt[g];
        g_cnt_r[g] <= g_cnt_nxt[g];
      end
    end
    if (phase_r == PH_REDUCE) begin
      hit_r  <= hit_nxt;
      pos_r  <= pos_nxt;
      hcnt_r <= hcnt_nxt;
    end
    if (in_update) begin
      out_was_hit       <= hit_r;
      out_evicted_valid <= !hit_r && full;
      out_evicted_key   <= (!hit_r && full) ? ev_wide[OUT_KEY_W-1:0] : '0;
      out_hit_total     <= hits_nxt;
      out_miss_total    <= misses_nxt;
    end
  end

  // ---- checks ----
  a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(phase_r == PH_UPDATE))
    else $error("result strobe without an update cycle");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_MAX)
    else $error("occupancy beyond frame count");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_update |-> $onehot0(match_a))
    else $error("key resident in more than one cell");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_hit |-> !out_evicted_valid)
    else $error("eviction reported on a hit");

  a_occ_grows_on_miss_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_update && hit_r |=> $stable(occ_r))
    else $error("occupancy changed on a hit");

endmodule

// ===== test/testbench.sv =====
// Testbench for lfu_page_replacement: drives page requests and frame-limit writes, and
// checks every result strobe against an in-bench LFU list predictor.
// Depends on lfu_pkg and the lfu_page_replacement RTL.
`timescale 1ns / 100ps

module testbench;
  import lfu_pkg::*;

  localparam int FRAMES      = 512;
  localparam int POOL_DEPTH  = 96;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct packed {
    logic                 was_hit;
    logic                 evicted_valid;
    logic [OUT_KEY_W-1:0] evicted_key;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
  } outcome_t;

  class lfu_scoreboard;
    logic [OUT_KEY_W-1:0] resident_key[FRAMES];
    logic [CNT_W-1:0]     use_count[FRAMES];
    int unsigned          occupancy;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
    logic [LIMIT_W-1:0]   frame_limit;
    outcome_t             expected_outcomes[$];
    int                   errors;

    function new();
      occupancy   = 0;
      hits        = '0;
      misses      = '0;
      frame_limit = LIMIT_RESET;
      errors      = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      frame_limit = value;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    // Update the LFU list for one accepted request and queue its outcome.
    function void note_request(logic [OUT_KEY_W-1:0] key);
      int unsigned      n;
      int unsigned      pos;
      int unsigned      cap;
      logic             hit;
      logic [CNT_W-1:0] cnt;
      outcome_t         o;
      n   = occupancy;
      pos = n;
      hit = 1'b0;
      o   = '0;
      for (int i = 0; i < n; i++) begin
        if (resident_key[i] == key) begin
          pos = i;
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        cnt = use_count[pos];
        if (cnt != CNT_MAX) cnt++;
        // advance past strictly smaller counts only; equal counts keep order
        while (pos + 1 < n && use_count[pos+1] < cnt) begin
          resident_key[pos] = resident_key[pos+1];
          use_count[pos]    = use_count[pos+1];
          pos++;
        end
        resident_key[pos] = key;
        use_count[pos]    = cnt;
        if (hits != CNT_MAX) hits++;
      end else begin
        cap = (frame_limit == 0) ? 1 : ((frame_limit > FRAMES) ? FRAMES : frame_limit);
        if (n >= cap && n > 0) begin
          o.evicted_valid = 1'b1;
          o.evicted_key   = resident_key[0];
        end else begin
          for (int i = n; i > 0; i--) begin
            resident_key[i] = resident_key[i-1];
            use_count[i]    = use_count[i-1];
          end
          n++;
        end
        resident_key[0] = key;
        use_count[0]    = CNT_ONE;
        if (misses != CNT_MAX) misses++;
      end
      occupancy    = n;
      o.was_hit    = hit;
      o.hit_total  = hits;
      o.miss_total = misses;
      expected_outcomes.push_back(o);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_outcome(outcome_t got);
      outcome_t exp;
      if (expected_outcomes.size() == 0) begin
        report("result strobe with no request outstanding");
        return;
      end
      // take the oldest outstanding request
      exp = expected_outcomes[0];
      expected_outcomes.delete(0);
      if (got.was_hit !== exp.was_hit)
        report($sformatf("was_hit %b, expected %b", got.was_hit, exp.was_hit));
      if (got.evicted_valid !== exp.evicted_valid)
        report($sformatf("evicted_valid %b, expected %b",
                         got.evicted_valid, exp.evicted_valid));
      if (got.evicted_key !== exp.evicted_key)
        report($sformatf("evicted_key %h, expected %h", got.evicted_key, exp.evicted_key));
      if (got.hit_total !== exp.hit_total)
        report($sformatf("hit_total %0d, expected %0d", got.hit_total, exp.hit_total));
      if (got.miss_total !== exp.miss_total)
        report($sformatf("miss_total %0d, expected %0d", got.miss_total, exp.miss_total));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OUT_KEY_W-1:0] in_page_key;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data;
  logic                 out_valid;
  logic                 out_was_hit;
  logic                 out_evicted_valid;
  logic [OUT_KEY_W-1:0] out_evicted_key;
  logic [CNT_W-1:0]     out_hit_total;
  logic [CNT_W-1:0]     out_miss_total;

  lfu_scoreboard        sb = new();
  logic [OUT_KEY_W-1:0] key_pool[POOL_DEPTH];
  int                   cycle_count = 0;

  lfu_page_replacement #(.MAX_FRAMES(FRAMES), .KEY_BITS(OUT_KEY_W)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_key       (in_page_key),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_was_hit       (out_was_hit),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_outcome({out_was_hit, out_evicted_valid, out_evicted_key,
                        out_hit_total, out_miss_total});
  end

  function automatic logic [OUT_KEY_W-1:0] random_key();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[OUT_KEY_W-1:0];
  endfunction

  // Hold start high until the request is taken.
  task automatic send_request(logic [OUT_KEY_W-1:0] key);
    start       <= 1'b1;
    in_page_key <= key;
    do @(posedge clk); while (busy);
    sb.note_request(key);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(value);
  endtask

  // Mostly pool keys skewed toward the low indexes, so counts spread out;
  // the rest are fresh random keys.
  task automatic run_phase(logic [LIMIT_W-1:0] limit, int count, int phase);
    int cap;
    int pool_size;
    int burst_left;
    int idx;
    logic [OUT_KEY_W-1:0] key;
    write_limit(limit);
    cap        = (limit == 0) ? 1 : ((limit > FRAMES) ? FRAMES : limit);
    pool_size  = cap + cap / 2 + 2;
    if (pool_size > POOL_DEPTH) pool_size = POOL_DEPTH;
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        idx = $urandom_range(0, $urandom_range(0, pool_size - 1));
        key = key_pool[idx];
      end else begin
        key = random_key();
      end
      send_request(key);
      if (phase == 3 && i == count / 2) wait_drain();
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        // no idling on every third phase
        if (phase % 3 != 2) pause($urandom_range(0, 6));
      end
    end
  endtask

  initial begin
    logic [OUT_KEY_W-1:0] directed[$];
    logic [LIMIT_W-1:0]   limits[$];
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_page_key <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = random_key();
    key_pool[1] = '0;
    key_pool[2] = '1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme keys, hits that reorder, equal-count ties, then a
    // limit below occupancy so misses only replace the front.
    directed = '{40'h0, 40'hFF_FFFF_FFFF, 40'h0, 40'hAA_AAAA_AAAA, 40'h55_5555_5555,
                 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hAA_AAAA_AAAA, 40'h55_5555_5555,
                 40'h55_5555_5555, 40'h0, 40'h80_0000_0001, 40'h00_0000_0001};
    foreach (directed[i]) send_request(directed[i]);
    write_limit(10'd2);
    directed = '{40'h12_3456_789A, 40'h80_0000_0001, 40'h0, 40'hFE_DCBA_9876,
                 40'h12_3456_789A, 40'hFF_FFFF_FFFF, 40'h55_5555_5555};
    foreach (directed[i]) send_request(directed[i]);
    write_limit(10'd0);
    send_request(40'h0);
    send_request(40'h0);
    send_request(40'h7F_FFFF_FFFF);
    send_request(40'h0);

    limits = '{10'd1023, 10'd1, 10'd7, 10'd40, 10'd3, 10'd0, 10'd512, 10'd64, 10'd16, 10'd2};
    foreach (limits[p]) run_phase(limits[p], 48, p);

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
